@@ src/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the timestamp parser
// Word types, parse phases, sequencer steps and calendar constants.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam logic [13:0] EARLIEST_YEAR_RST = 14'd2023;
  localparam logic [4:0]  FIXED_LEN         = 5'd19;
  localparam logic [6:0]  OFFSET_SAT        = 7'd99;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned ERA_DAYS    = 146097;
  localparam int unsigned SHIFT_YEARS = 400;
  localparam int unsigned EPOCH_DAYS  = 719468;
  localparam logic [39:0] DAYS_BIAS   = 40'(EPOCH_DAYS + ERA_DAYS);
  localparam logic [14:0] YEAR_SHIFT  = 15'(SHIFT_YEARS);
  localparam logic [17:0] RECIP_25    = 18'd5243;
  localparam int unsigned RECIP_SHIFT = 17;

  typedef enum logic [2:0] {
    PH_MAIN     = 3'd0,
    PH_SKIP     = 3'd1,
    PH_OH_FIRST = 3'd2,
    PH_OH       = 3'd3,
    PH_OM_FIRST = 3'd4,
    PH_OM       = 3'd5,
    PH_DONE     = 3'd6
  } itp_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_DIV   = 4'd1,
    ST_DAYS  = 4'd2,
    ST_SEC_D = 4'd3,
    ST_SEC_H = 4'd4,
    ST_SEC_M = 4'd5,
    ST_OFF_H = 4'd6,
    ST_OFF_M = 4'd7,
    ST_DONE  = 4'd8
  } itp_step_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } itp_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [37:0] unix_time;
  } itp_out_t;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        zone_neg;
    logic [6:0]  off_hour;
    logic [6:0]  off_minute;
    logic        format_ok;
  } itp_fields_t;

  // Days from March 1 to the first day of the given month.
  function automatic logic [8:0] itp_month_base(input logic [6:0] month);
    logic [8:0] base;
    case (month)
      7'd3:    base = 9'd0;
      7'd4:    base = 9'd31;
      7'd5:    base = 9'd61;
      7'd6:    base = 9'd92;
      7'd7:    base = 9'd122;
      7'd8:    base = 9'd153;
      7'd9:    base = 9'd184;
      7'd10:   base = 9'd214;
      7'd11:   base = 9'd245;
      7'd12:   base = 9'd275;
      7'd1:    base = 9'd306;
      7'd2:    base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

@@ src/itp_scanner.sv @@
// ----------------------------------------------------------------------------
// itp_scanner: byte-wise timestamp text scanner
// Collects the date, time and zone fields one text byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_scanner
  import itp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire itp_in_t     in_i,
  output      itp_fields_t fields_o
);

  localparam logic [4:0] POS_YEAR_END  = 5'd3;
  localparam logic [4:0] POS_MON_DASH  = 5'd4;
  localparam logic [4:0] POS_MON_END   = 5'd6;
  localparam logic [4:0] POS_DAY_DASH  = 5'd7;
  localparam logic [4:0] POS_DAY_END   = 5'd9;
  localparam logic [4:0] POS_T         = 5'd10;
  localparam logic [4:0] POS_HOUR_END  = 5'd12;
  localparam logic [4:0] POS_MIN_COLON = 5'd13;
  localparam logic [4:0] POS_MIN_END   = 5'd15;
  localparam logic [4:0] POS_SEC_COLON = 5'd16;

  itp_phase_e  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic        neg_q, neg_d;
  logic [6:0]  oh_q, oh_d;
  logic [6:0]  om_q, om_d;
  logic        err_q, err_d;

  logic [7:0]  c;
  logic        dig;
  logic [3:0]  d;
  logic [9:0]  oh_n, om_n;

  function automatic logic [6:0] acc2(input logic [6:0] v, input logic [3:0] dv);
    return 7'(11'(v) * 11'd10 + 11'(dv));
  endfunction

  assign c    = in_i.text_byte;
  assign dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d    = dig ? 4'(c - CH_ZERO) : 4'd0;
  assign oh_n = 10'(oh_q) * 10'd10 + 10'(d);
  assign om_n = 10'(om_q) * 10'd10 + 10'(d);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    neg_d    = neg_q;
    oh_d     = oh_q;
    om_d     = om_q;
    err_d    = err_q;
    if (accept_i) begin
      case (phase_q)
        PH_MAIN: begin
          if (pos_q == POS_MON_DASH || pos_q == POS_DAY_DASH) begin
            if (c != CH_DASH) err_d = 1'b1;
          end else if (pos_q == POS_T) begin
            if (c != CH_T) err_d = 1'b1;
          end else if (pos_q == POS_MIN_COLON || pos_q == POS_SEC_COLON) begin
            if (c != CH_COLON) err_d = 1'b1;
          end else if (!dig) begin
            err_d = 1'b1;
          end else if (pos_q <= POS_YEAR_END) begin
            year_d = 14'(18'(year_q) * 18'd10 + 18'(d));
          end else if (pos_q <= POS_MON_END) begin
            month_d = acc2(month_q, d);
          end else if (pos_q <= POS_DAY_END) begin
            day_d = acc2(day_q, d);
          end else if (pos_q <= POS_HOUR_END) begin
            hour_d = acc2(hour_q, d);
          end else if (pos_q <= POS_MIN_END) begin
            minute_d = acc2(minute_q, d);
          end else begin
            second_d = acc2(second_q, d);
          end
          pos_d = pos_q + 5'd1;
          if (pos_d >= FIXED_LEN) begin
            pos_d   = FIXED_LEN;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (c == CH_PLUS) begin
            neg_d   = 1'b0;
            phase_d = PH_OH_FIRST;
          end else if (c == CH_DASH) begin
            neg_d   = 1'b1;
            phase_d = PH_OH_FIRST;
          end else if (c == CH_Z) begin
            phase_d = PH_DONE;
          end else if (c == CH_NUL) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_OH_FIRST, PH_OH: begin
          if (dig) begin
            oh_d    = (oh_n > 10'(OFFSET_SAT)) ? OFFSET_SAT : oh_n[6:0];
            phase_d = PH_OH;
          end else if (c == CH_COLON && phase_q == PH_OH) begin
            phase_d = PH_OM_FIRST;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_OM_FIRST: begin
          if (dig) begin
            om_d    = (om_n > 10'(OFFSET_SAT)) ? OFFSET_SAT : om_n[6:0];
            phase_d = PH_OM;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_OM: begin
          if (dig) begin
            om_d = (om_n > 10'(OFFSET_SAT)) ? OFFSET_SAT : om_n[6:0];
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    fields_o.year       = year_d;
    fields_o.month      = month_d;
    fields_o.day        = day_d;
    fields_o.hour       = hour_d;
    fields_o.minute     = minute_d;
    fields_o.second     = second_d;
    fields_o.zone_neg   = neg_d;
    fields_o.off_hour   = oh_d;
    fields_o.off_minute = om_d;
    fields_o.format_ok  = !err_d && (phase_d == PH_OM || phase_d == PH_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAIN;
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      neg_q    <= 1'b0;
      oh_q     <= '0;
      om_q     <= '0;
      err_q    <= 1'b0;
    end else if (accept_i && in_i.end_of_text) begin
      phase_q  <= PH_MAIN;
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      neg_q    <= 1'b0;
      oh_q     <= '0;
      om_q     <= '0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      neg_q    <= neg_d;
      oh_q     <= oh_d;
      om_q     <= om_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ src/itp_mac.sv @@
// ----------------------------------------------------------------------------
// itp_mac: shared multiply-accumulate unit
// Registers a * b + c when enabled; used for every multiply-add step of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_mac (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [23:0] a_i,
  input  wire logic signed [17:0] b_i,
  input  wire logic signed [39:0] c_i,
  output      logic signed [39:0] acc_o
);

  logic signed [41:0] prod;
  logic signed [39:0] acc_q, acc_d;

  assign prod  = a_i * b_i;
  assign acc_d = c_i + prod[39:0];
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

@@ src/itp_convert.sv @@
// ----------------------------------------------------------------------------
// itp_convert: range check and civil date to epoch conversion
// A small sequencer drives the shared multiply-accumulate unit step by step.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_convert
  import itp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire itp_fields_t fields_i,
  input  wire logic [13:0] earliest_year_i,
  output      logic        busy_o,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      itp_out_t    out_data_o
);

  itp_step_e   state_q, state_d;
  itp_fields_t f_q;
  logic        ok_q;
  logic        range_ok;
  logic        out_valid_q, out_valid_d;
  itp_out_t    out_q;
  logic        out_load;
  logic        res_ok;

  logic        mac_en;
  logic signed [23:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [39:0] mac_c;
  logic signed [39:0] acc;

  logic [14:0] y_shift;
  logic [12:0] y4;
  logic [6:0]  q100;
  logic [4:0]  q400;
  logic [39:0] k_u;

  assign range_ok = fields_i.format_ok &&
                    fields_i.year >= earliest_year_i &&
                    fields_i.month >= 7'd1 && fields_i.month <= 7'd12 &&
                    fields_i.day >= 7'd1 && fields_i.day <= 7'd31 &&
                    fields_i.hour <= 7'd23 && fields_i.minute <= 7'd59 &&
                    fields_i.second <= 7'd60 && fields_i.off_hour <= 7'd23 &&
                    fields_i.off_minute <= 7'd59;

  assign y_shift = 15'(f_q.year) + YEAR_SHIFT - ((f_q.month <= 7'd2) ? 15'd1 : 15'd0);
  assign y4      = y_shift[14:2];
  assign q100    = acc[RECIP_SHIFT+6:RECIP_SHIFT];
  assign q400    = q100[6:2];
  assign k_u     = 40'(y4) - 40'(q100) + 40'(q400) + 40'(itp_month_base(f_q.month)) +
                   40'(f_q.day) - 40'd1 - DAYS_BIAS;

  itp_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .acc_o (acc)
  );

  assign res_ok = ok_q && !acc[39];

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    mac_en      = 1'b1;
    mac_a       = '0;
    mac_b       = '0;
    mac_c       = acc;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        mac_en = 1'b0;
        if (start_i) state_d = range_ok ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        mac_a   = $signed(24'(y4));
        mac_b   = $signed(RECIP_25);
        mac_c   = '0;
        state_d = ST_DAYS;
      end
      ST_DAYS: begin
        mac_a   = $signed(24'(y_shift));
        mac_b   = 18'sd365;
        mac_c   = $signed(k_u);
        state_d = ST_SEC_D;
      end
      ST_SEC_D: begin
        mac_a   = acc[23:0];
        mac_b   = 18'sd86400;
        mac_c   = $signed(40'(f_q.second));
        state_d = ST_SEC_H;
      end
      ST_SEC_H: begin
        mac_a   = $signed(24'(f_q.hour));
        mac_b   = 18'sd3600;
        state_d = ST_SEC_M;
      end
      ST_SEC_M: begin
        mac_a   = $signed(24'(f_q.minute));
        mac_b   = 18'sd60;
        state_d = ST_OFF_H;
      end
      ST_OFF_H: begin
        mac_a   = $signed(24'(f_q.off_hour));
        mac_b   = f_q.zone_neg ? 18'sd3600 : -18'sd3600;
        state_d = ST_OFF_M;
      end
      ST_OFF_M: begin
        mac_a   = $signed(24'(f_q.off_minute));
        mac_b   = f_q.zone_neg ? 18'sd60 : -18'sd60;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        mac_en = 1'b0;
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        mac_en  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      f_q  <= fields_i;
      ok_q <= range_ok;
    end
    if (out_load) begin
      out_q.valid_res <= res_ok;
      out_q.unix_time <= res_ok ? acc[37:0] : '0;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ src/iso_timestamp_to_epoch_parser.sv @@
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_parser: ISO 8601 timestamp text to Unix epoch
// Scans timestamp text bytes and converts the final fields to epoch seconds.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  in      | input     | itp_in_t  (text_byte, end_of_text)
//  out     | output    | itp_out_t (valid_res, unix_time)
//  cfg     | input     | earliest_year, 14 bits
//
//  Text bytes are taken one per cycle while no conversion is running.
//  A final byte starts the conversion: seven multiply-add steps and a load, so
//  input is held off until the result is loaded; a failed check skips the steps.
//  An unread result word does not stop scanning, but the next conversion waits
//  in its load step until that word is taken.
//  Reset clears the parse state and the sequencer and sets earliest_year to 2023.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_timestamp_to_epoch_parser
  import itp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire itp_in_t     in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      itp_out_t    out_data_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [13:0] cfg_data_i
);

  logic        earliest_year_q;
  logic [13:0] year_min_q;
  logic        in_accept;
  logic        conv_busy;
  itp_fields_t fields;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !conv_busy;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_min_q      <= EARLIEST_YEAR_RST;
      earliest_year_q <= 1'b0;
    end else begin
      earliest_year_q <= cfg_valid_i;
      if (cfg_valid_i && cfg_ready_o) year_min_q <= cfg_data_i;
    end
  end

  itp_scanner u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .in_i     (in_data_i),
    .fields_o (fields)
  );

  itp_convert u_convert (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (in_accept && in_data_i.end_of_text),
    .fields_i        (fields),
    .earliest_year_i (year_min_q),
    .busy_o          (conv_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o)
  );

`ifndef SYNTHESIS
  a_final_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_text |=> !in_ready_o)
    else $error("input still ready after a final byte");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.unix_time == 38'd0)
    else $error("invalid result carries a nonzero epoch");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sequencer not idle when a result appears");

  a_cfg_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    earliest_year_q |-> year_min_q == $past(cfg_data_i))
    else $error("configuration write not taken");
`endif

endmodule

`default_nettype wire

@@ tb/tb_iso_timestamp_to_epoch_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso_timestamp_to_epoch_parser: self-checking bench of the timestamp parser
// Feeds timestamp text one word per byte, predicts each epoch result in the
// bench and compares every returned word field by field, under random idling
// on both channels and several settings of the earliest accepted year.
// ----------------------------------------------------------------------------

module tb_iso_timestamp_to_epoch_parser;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int SETTLE       = 20;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  itp_in_t     in_data = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [13:0] cfg_data = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  itp_out_t    out_data_o;
  logic        cfg_ready_o;

  int send_idle_pct = 34;
  int recv_idle_pct = 61;
  int error_count = 0;
  int cycle_count = 0;
  int texts_sent = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int year_writes = 0;

  logic [7:0] text_q[$];
  itp_out_t   pending_epochs[$];

  itp_phase_e  scan_phase;
  logic [4:0]  scan_pos;
  logic [13:0] ts_year;
  logic [6:0]  ts_month, ts_day, ts_hour, ts_minute, ts_second;
  logic        ts_zone_neg;
  logic [6:0]  ts_off_hour, ts_off_minute;
  logic        ts_bad_format;
  logic [13:0] min_year;

  iso_timestamp_to_epoch_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_timestamp();
    scan_phase    = PH_MAIN;
    scan_pos      = '0;
    ts_year       = '0;
    ts_month      = '0;
    ts_day        = '0;
    ts_hour       = '0;
    ts_minute     = '0;
    ts_second     = '0;
    ts_zone_neg   = 1'b0;
    ts_off_hour   = '0;
    ts_off_minute = '0;
    ts_bad_format = 1'b0;
  endfunction

  function automatic void predict_epoch(input logic [7:0] c, input logic last);
    logic     is_digit;
    int       dv;
    int       sat;
    logic     ok;
    longint   y, m, era, yoe, mp, doy, doe, secs, off;
    itp_out_t res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dv = is_digit ? int'(c - CH_ZERO) : 0;
    case (scan_phase)
      PH_MAIN: begin
        if (scan_pos == 5'd4 || scan_pos == 5'd7) begin
          if (c != CH_DASH) ts_bad_format = 1'b1;
        end else if (scan_pos == 5'd10) begin
          if (c != CH_T) ts_bad_format = 1'b1;
        end else if (scan_pos == 5'd13 || scan_pos == 5'd16) begin
          if (c != CH_COLON) ts_bad_format = 1'b1;
        end else if (!is_digit) begin
          ts_bad_format = 1'b1;
        end else if (scan_pos <= 5'd3) begin
          ts_year = 14'(int'(ts_year) * 10 + dv);
        end else if (scan_pos <= 5'd6) begin
          ts_month = 7'(int'(ts_month) * 10 + dv);
        end else if (scan_pos <= 5'd9) begin
          ts_day = 7'(int'(ts_day) * 10 + dv);
        end else if (scan_pos <= 5'd12) begin
          ts_hour = 7'(int'(ts_hour) * 10 + dv);
        end else if (scan_pos <= 5'd15) begin
          ts_minute = 7'(int'(ts_minute) * 10 + dv);
        end else begin
          ts_second = 7'(int'(ts_second) * 10 + dv);
        end
        scan_pos = scan_pos + 5'd1;
        if (scan_pos >= FIXED_LEN) begin
          scan_pos = FIXED_LEN;
          scan_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c == CH_PLUS) begin
          ts_zone_neg = 1'b0;
          scan_phase = PH_OH_FIRST;
        end else if (c == CH_DASH) begin
          ts_zone_neg = 1'b1;
          scan_phase = PH_OH_FIRST;
        end else if (c == CH_Z) begin
          scan_phase = PH_DONE;
        end else if (c == CH_NUL) begin
          ts_bad_format = 1'b1;
          scan_phase = PH_DONE;
        end
      end
      PH_OH_FIRST, PH_OH: begin
        if (is_digit) begin
          sat = int'(ts_off_hour) * 10 + dv;
          ts_off_hour = (sat > int'(OFFSET_SAT)) ? OFFSET_SAT : 7'(sat);
          scan_phase = PH_OH;
        end else if (c == CH_COLON && scan_phase == PH_OH) begin
          scan_phase = PH_OM_FIRST;
        end else begin
          ts_bad_format = 1'b1;
          scan_phase = PH_DONE;
        end
      end
      PH_OM_FIRST, PH_OM: begin
        if (is_digit) begin
          sat = int'(ts_off_minute) * 10 + dv;
          ts_off_minute = (sat > int'(OFFSET_SAT)) ? OFFSET_SAT : 7'(sat);
          scan_phase = PH_OM;
        end else if (scan_phase == PH_OM) begin
          scan_phase = PH_DONE;
        end else begin
          ts_bad_format = 1'b1;
          scan_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (!last) return;

    ok = !ts_bad_format && (scan_phase == PH_OM || scan_phase == PH_DONE) &&
         ts_year >= min_year && ts_month >= 7'd1 && ts_month <= 7'd12 &&
         ts_day >= 7'd1 && ts_day <= 7'd31 && ts_hour <= 7'd23 &&
         ts_minute <= 7'd59 && ts_second <= 7'd60 &&
         ts_off_hour <= 7'd23 && ts_off_minute <= 7'd59;
    secs = 0;
    if (ok) begin
      y = longint'(ts_year);
      m = longint'(ts_month);
      if (m <= 2) y = y - 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      mp = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + longint'(ts_day) - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      secs = (era * 146097 + doe - 719468) * 86400 + longint'(ts_hour) * 3600 +
             longint'(ts_minute) * 60 + longint'(ts_second);
      off = longint'(ts_off_hour) * 3600 + longint'(ts_off_minute) * 60;
      secs = ts_zone_neg ? secs + off : secs - off;
      if (secs < 0) begin
        ok = 1'b0;
        secs = 0;
      end
    end
    res.valid_res = ok;
    res.unix_time = ok ? secs[37:0] : '0;
    pending_epochs.push_back(res);
    clear_timestamp();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    itp_out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_epochs.size() == 0) begin
        report_mismatch("result with no timestamp pending",
                        64'(out_data_o.unix_time), 64'd0);
      end else begin
        want = pending_epochs.pop_front();
        if (out_data_o.valid_res !== want.valid_res)
          report_mismatch("valid_res", 64'(out_data_o.valid_res), 64'(want.valid_res));
        if (out_data_o.unix_time !== want.unix_time)
          report_mismatch("unix_time", 64'(out_data_o.unix_time), 64'(want.unix_time));
        results_checked++;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    itp_in_t word;
    word.text_byte = c;
    word.end_of_text = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    predict_epoch(c, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    bytes_sent += text_q.size();
    texts_sent++;
    text_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_epochs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_earliest_year(input logic [13:0] year);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= year;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    min_year = year;
    year_writes++;
  endtask

  function automatic void push_num(input int value, input int ndigits);
    int p;
    for (int i = ndigits - 1; i >= 0; i--) begin
      p = 1;
      repeat (i) p = p * 10;
      text_q.push_back(CH_ZERO + 8'((value / p) % 10));
    end
  endfunction

  function automatic void push_fixed(input int y, input int mo, input int d,
                                     input int h, input int mi, input int s);
    push_num(y, 4);
    text_q.push_back(CH_DASH);
    push_num(mo, 2);
    text_q.push_back(CH_DASH);
    push_num(d, 2);
    text_q.push_back(CH_T);
    push_num(h, 2);
    text_q.push_back(CH_COLON);
    push_num(mi, 2);
    text_q.push_back(CH_COLON);
    push_num(s, 2);
  endfunction

  function automatic void push_offset(input logic neg, input int oh, input int ohd,
                                      input int om, input int omd);
    text_q.push_back(neg ? CH_DASH : CH_PLUS);
    push_num(oh, ohd);
    text_q.push_back(CH_COLON);
    push_num(om, omd);
  endfunction

  function automatic int pick_field(input int lo, input int hi);
    if ($urandom_range(9) == 0) return int'($urandom_range(0, 99));
    return int'($urandom_range(lo, hi));
  endfunction

  task automatic test_default_year();
    push_fixed(2023, 1, 1, 0, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2022, 12, 31, 23, 59, 59);
    text_q.push_back(CH_Z);
    send_text();
  endtask

  task automatic test_field_limits();
    push_fixed(9999, 12, 31, 23, 59, 60);
    push_offset(1'b1, 23, 2, 59, 2);
    send_text();
    push_fixed(2030, 0, 15, 12, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 13, 1, 12, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 5, 0, 12, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 5, 32, 12, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 5, 9, 24, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 5, 9, 7, 60, 0);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2030, 5, 9, 7, 5, 61);
    text_q.push_back(CH_Z);
    send_text();
  endtask

  task automatic test_zone_forms();
    push_fixed(2031, 7, 4, 10, 20, 30);
    push_offset(1'b0, 5, 2, 30, 2);
    send_text();
    push_fixed(2031, 7, 4, 10, 20, 30);
    push_offset(1'b1, 1, 1, 7, 1);
    send_text();
    push_fixed(2031, 7, 4, 10, 20, 30);
    push_offset(1'b0, 100, 3, 0, 2);
    send_text();
    push_fixed(2031, 7, 4, 10, 20, 30);
    push_offset(1'b1, 0, 2, 100, 3);
    send_text();
    push_fixed(2031, 7, 4, 10, 20, 30);
    text_q.push_back(CH_DOT);
    push_num(123, 3);
    text_q.push_back(CH_Z);
    text_q.push_back(CH_LOWER_X);
    send_text();
    push_fixed(2031, 7, 4, 10, 20, 30);
    push_offset(1'b0, 1, 2, 0, 2);
    text_q.push_back(CH_LOWER_X);
    text_q.push_back(CH_PLUS);
    send_text();
  endtask

  task automatic test_malformed_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q[4] = CH_SLASH;
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q[9] = CH_LOWER_X;
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    while (text_q.size() > 6) void'(text_q.pop_back());
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q.push_back(CH_NUL);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q.push_back(CH_PLUS);
    text_q.push_back(CH_LOWER_X);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q.push_back(CH_PLUS);
    push_num(5, 2);
    text_q.push_back(CH_LOWER_X);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q.push_back(CH_PLUS);
    push_num(5, 2);
    text_q.push_back(CH_COLON);
    text_q.push_back(CH_LOWER_X);
    send_text();
    push_fixed(2040, 2, 2, 2, 2, 2);
    text_q.push_back(CH_DASH);
    send_text();
  endtask

  task automatic test_epoch_floor();
    write_earliest_year(14'd0);
    push_fixed(1969, 12, 31, 23, 59, 59);
    text_q.push_back(CH_Z);
    send_text();
    push_fixed(1970, 1, 1, 0, 0, 0);
    push_offset(1'b0, 0, 2, 1, 2);
    send_text();
    push_fixed(1970, 1, 1, 0, 0, 0);
    push_offset(1'b1, 0, 2, 1, 2);
    send_text();
    push_fixed(0, 1, 1, 0, 0, 0);
    text_q.push_back(CH_Z);
    send_text();
  endtask

  task automatic test_year_register();
    write_earliest_year(14'h3FFF);
    push_fixed(9999, 6, 6, 6, 6, 6);
    text_q.push_back(CH_Z);
    send_text();
    write_earliest_year(14'd9999);
    push_fixed(9999, 6, 6, 6, 6, 6);
    text_q.push_back(CH_Z);
    send_text();
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle,
                                     input logic [13:0] year_floor, input int nbytes);
    int sent, kind, y, ohd, omd, n, texts;
    logic [7:0] c;
    write_earliest_year(year_floor);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    texts = 0;
    while (sent < nbytes) begin
      kind = int'($urandom_range(99));
      if (kind < 12) begin
        n = int'($urandom_range(1, 30));
        repeat (n) text_q.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) begin
          y = int'($urandom_range(0, 9999));
        end else begin
          y = int'(year_floor) + int'($urandom_range(0, 60)) - 2;
          if (y < 0) y = 0;
          if (y > 9999) y = 9999;
        end
        push_fixed(y, pick_field(1, 12), pick_field(1, 31), pick_field(0, 23),
                   pick_field(0, 59), pick_field(0, 60));
        if ($urandom_range(3) == 0) begin
          text_q.push_back(CH_DOT);
          repeat ($urandom_range(1, 6)) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        case ($urandom_range(9))
          0, 1, 2: text_q.push_back(CH_Z);
          9: ;
          default: begin
            ohd = ($urandom_range(4) == 0) ? int'($urandom_range(1, 3)) : 2;
            omd = ($urandom_range(4) == 0) ? int'($urandom_range(1, 3)) : 2;
            push_offset(1'($urandom_range(1)),
                        ($urandom_range(9) == 0) ? int'($urandom_range(0, 999))
                                                 : int'($urandom_range(0, 23)), ohd,
                        ($urandom_range(9) == 0) ? int'($urandom_range(0, 999))
                                                 : int'($urandom_range(0, 59)), omd);
          end
        endcase
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
        end
        if (kind >= 80) begin
          if ($urandom_range(1) == 0) begin
            c = 8'($urandom_range(255));
            text_q[$urandom_range(0, text_q.size() - 1)] = c;
          end else begin
            n = int'($urandom_range(1, text_q.size() - 1));
            while (text_q.size() > n) void'(text_q.pop_back());
          end
        end
      end
      sent += text_q.size();
      send_text();
      texts++;
      if (texts == 3 || $urandom_range(15) == 0) wait_drained();
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    clear_timestamp();
    min_year = EARLIEST_YEAR_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_year();
    test_field_limits();
    test_zone_forms();
    test_malformed_text();
    test_epoch_floor();
    test_year_register();
    test_random_traffic(34, 61, 14'd1970, 370);
    test_random_traffic(61, 34, 14'($urandom_range(0, 2100)), 350);
    test_random_traffic(0, 0, EARLIEST_YEAR_RST, 340);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d timestamps (%0d bytes), checked %0d results, %0d year writes.",
             texts_sent, bytes_sent, results_checked, year_writes);
    $display("Covered field limits, zone offsets, malformed and truncated text, noise.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
